// ===== hw/rtl/mobd_pkg.sv =====
package mobd_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int DIST_BITS      = 24;
   localparam int RATIO_BITS     = 30;
   localparam int DEPTH_BITS     = 20;
   localparam int DEPTH_SCALE    = 200;
   localparam int DEPTH_SHIFT    = 18;
   localparam int DEPTH_ROUND    = 1 << (DEPTH_SHIFT - 1);
   localparam int LAT_SCALE      = 10240;
   localparam int LAT_EXTRA      = 15;
   localparam int DIST_SHIFT     = 4;
   localparam int DIST_ROUND     = 1 << (DIST_SHIFT - 1);
   localparam int IN_DEPTH       = 4;
   localparam int OUT_DEPTH      = 2;
   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQR,
      ST_CUBE,
      ST_DEPTH,
      ST_DEPTH_SQ,
      ST_HAND
   } stage_state_type;

   function automatic int lat_bits(input int c);
      return c + LAT_EXTRA;
   endfunction

   function automatic int item_bits(input int c);
      return 7 * c + 18;
   endfunction

   function automatic int res_bits(input int c);
      return 4 * c + 2 + DIST_BITS;
   endfunction

endpackage

// ===== hw/rtl/monocular_object_distance.sv =====
// channel   ports                       handshake
// request   req_push / req_full         taken when req_push and not req_full
// response  rsp_empty / rsp_pop         taken when rsp_pop and not rsp_empty
// csr       csr_valid / csr_ready       written when csr_valid and csr_ready
//
// the front end classifies a request in its accept cycle and queues it (four deep)
// the back end works on one request at a time, paced by the radix-4 dividers:
// a take, the division, the square, cube, depth and depth-square multiplies and a hand-over
// the square root runs in its own stage, overlapped with the next division
// reset is synchronous and clears queues and control; no clearing pass
// a full response queue stalls the root stage, then the dividers, then req_full
module monocular_object_distance #(
   parameter int COORD_BITS = mobd_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_tracks_found,
   input  logic [COORD_BITS-1:0] req_left_rail_x,
   input  logic [COORD_BITS-1:0] req_right_rail_x,
   input  logic [COORD_BITS-1:0] req_box_left,
   input  logic [COORD_BITS-1:0] req_box_top,
   input  logic [COORD_BITS-1:0] req_box_width,
   input  logic [COORD_BITS-1:0] req_box_height,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_track_ref_x,
   output logic [COORD_BITS-1:0] rsp_track_ref_y,
   output logic [COORD_BITS:0]   rsp_vehicle_ref_x,
   output logic [COORD_BITS:0]   rsp_vehicle_ref_y,
   output logic [mobd_pkg::DIST_BITS-1:0] rsp_distance,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  mobd_pkg::csr_index_type csr_index,
   input  logic [COORD_BITS-1:0] csr_data
);
   localparam int IW = mobd_pkg::item_bits(COORD_BITS);
   localparam int RW = mobd_pkg::res_bits(COORD_BITS);

   logic [COORD_BITS-1:0] frame_width_ff, frame_height_ff;
   logic [IW-1:0]         item_in, item_head;
   logic                  q_empty, q_pop;
   logic [RW-1:0]         res_in, res_head;
   logic                  o_full, o_push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= COORD_BITS'(mobd_pkg::FRAME_WIDTH_RST);
         frame_height_ff <= COORD_BITS'(mobd_pkg::FRAME_HEIGHT_RST);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mobd_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            mobd_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: begin
               frame_width_ff <= frame_width_ff;
            end
         endcase
      end
   end

   mobd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .tracks_found (req_tracks_found),
      .left_rail_x  (req_left_rail_x),
      .right_rail_x (req_right_rail_x),
      .box_left     (req_box_left),
      .box_top      (req_box_top),
      .box_width    (req_box_width),
      .box_height   (req_box_height),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .item         (item_in)
   );

   mobd_fifo #(
      .WIDTH (IW),
      .DEPTH (mobd_pkg::IN_DEPTH)
   ) u_req_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .din   (item_in),
      .pop   (q_pop),
      .empty (q_empty),
      .dout  (item_head)
   );

   mobd_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_item   (item_head),
      .o_full   (o_full),
      .o_push   (o_push),
      .o_result (res_in)
   );

   mobd_fifo #(
      .WIDTH (RW),
      .DEPTH (mobd_pkg::OUT_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (o_push),
      .full  (o_full),
      .din   (res_in),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (res_head)
   );

   assign {rsp_track_ref_x, rsp_track_ref_y, rsp_vehicle_ref_x, rsp_vehicle_ref_y,
           rsp_distance} = res_head;
endmodule

// ===== hw/rtl/mobd_fifo.sv =====
module mobd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW + 1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

// ===== hw/rtl/mobd_front.sv =====
module mobd_front #(
   parameter int COORD_BITS = mobd_pkg::COORD_BITS_DEF
) (
   input  logic                  tracks_found,
   input  logic [COORD_BITS-1:0] left_rail_x,
   input  logic [COORD_BITS-1:0] right_rail_x,
   input  logic [COORD_BITS-1:0] box_left,
   input  logic [COORD_BITS-1:0] box_top,
   input  logic [COORD_BITS-1:0] box_width,
   input  logic [COORD_BITS-1:0] box_height,
   input  logic [COORD_BITS-1:0] frame_width,
   input  logic [COORD_BITS-1:0] frame_height,
   output logic [mobd_pkg::item_bits(COORD_BITS)-1:0] item
);
   localparam int C  = COORD_BITS;
   localparam int LW = mobd_pkg::lat_bits(COORD_BITS);

   typedef struct packed {
      logic [C-1:0]  tx;
      logic [C-1:0]  ty;
      logic [C:0]    vx;
      logic [C:0]    vy;
      logic          none;
      logic [C-1:0]  d;
      logic [LW-1:0] num;
      logic [C-1:0]  bw;
   } item_type;

   item_type     fields;
   logic [C:0]   rail_sum, vx_box, vy_box, tx_ext, adx;
   logic [C-1:0] tx;

   always_comb begin
      rail_sum = {1'b0, left_rail_x} + {1'b0, right_rail_x};
      tx       = tracks_found ? rail_sum[C:1] : (frame_width >> 1);
      tx_ext   = {1'b0, tx};
      vx_box   = {1'b0, box_left} + {2'b00, box_width[C-1:1]};
      vy_box   = {1'b0, box_top} + {1'b0, box_height};
      adx      = (tx_ext >= vx_box) ? tx_ext - vx_box : vx_box - tx_ext;

      fields.tx   = tx;
      fields.ty   = frame_height;
      fields.none = (box_width == '0);
      fields.vx   = fields.none ? tx_ext : vx_box;
      fields.vy   = fields.none ? {1'b0, frame_height} : vy_box;
      // below the frame bottom the height fraction clamps to zero
      fields.d    = (vy_box >= {1'b0, frame_height}) ? '0 : frame_height - vy_box[C-1:0];
      fields.num  = LW'(adx) * LW'(mobd_pkg::LAT_SCALE) + LW'(box_width[C-1:1]);
      fields.bw   = box_width;
   end

   assign item = fields;
endmodule

// ===== hw/rtl/mobd_div.sv =====
module mobd_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] rem_init,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int STEPS = (NUM_W + 1) / 2;
   localparam int PAD_W = 2 * STEPS;
   localparam int CW    = $clog2(STEPS + 1);

   logic [PAD_W-1:0] shift_ff, quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in, denom_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DEN_W:0]   t1, t2, m1, m2, den_ext;
   logic             ge1, ge2;

   // two restoring steps per cycle
   always_comb begin
      den_ext = {1'b0, denom_ff};
      t1      = {rem_ff, shift_ff[PAD_W-1]};
      ge1     = (t1 >= den_ext);
      m1      = ge1 ? t1 - den_ext : t1;
      t2      = {m1[DEN_W-1:0], shift_ff[PAD_W-2]};
      ge2     = (t2 >= den_ext);
      m2      = ge2 ? t2 - den_ext : t2;
      rem_in  = m2[DEN_W-1:0];
      quot_in = {quot_ff[PAD_W-3:0], ge1, ge2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= PAD_W'(numer);
         rem_ff   <= rem_init;
         denom_ff <= denom;
         quot_ff  <= '0;
      end else if (cnt_ff != '0) begin
         shift_ff <= {shift_ff[PAD_W-3:0], 2'b00};
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quot = quot_ff[NUM_W-1:0];
endmodule

// ===== hw/rtl/mobd_sqrt.sv =====
module mobd_sqrt #(
   parameter int ROOT_W = 28
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*ROOT_W-1:0] radicand,
   output logic                busy,
   output logic [ROOT_W-1:0]   root
);
   localparam int STEPS = ROOT_W / 2;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int RAD_W = 2 * ROOT_W;

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff, rt1, root_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W+2:0] t1, tr1, m1, t2, tr2, m2;
   logic [CW-1:0]     cnt_ff;
   logic              ge1, ge2;

   // two result bits per cycle
   always_comb begin
      t1      = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      tr1     = {1'b0, root_ff, 2'b01};
      ge1     = (t1 >= tr1);
      m1      = ge1 ? t1 - tr1 : t1;
      rt1     = {root_ff[ROOT_W-2:0], ge1};
      t2      = {m1[ROOT_W:0], rad_ff[RAD_W-3 -: 2]};
      tr2     = {1'b0, rt1, 2'b01};
      ge2     = (t2 >= tr2);
      m2      = ge2 ? t2 - tr2 : t2;
      root_in = {rt1[ROOT_W-2:0], ge2};
      rem_in  = m2[ROOT_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff  <= {rad_ff[RAD_W-5:0], 4'b0000};
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;
endmodule

// ===== hw/rtl/mobd_back.sv =====
module mobd_back #(
   parameter int COORD_BITS = mobd_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   output logic q_pop,
   input  logic [mobd_pkg::item_bits(COORD_BITS)-1:0] q_item,
   input  logic o_full,
   output logic o_push,
   output logic [mobd_pkg::res_bits(COORD_BITS)-1:0] o_result
);
   localparam int C      = COORD_BITS;
   localparam int LW     = mobd_pkg::lat_bits(COORD_BITS);
   localparam int RB     = mobd_pkg::RATIO_BITS;
   localparam int DB     = mobd_pkg::DEPTH_BITS;
   localparam int DBITS  = mobd_pkg::DIST_BITS;
   localparam int ROOT_W = ((LW + 2) / 2) * 2;
   localparam int DR_W   = ROOT_W + 1 - mobd_pkg::DIST_SHIFT;
   localparam int EXT_W  = (DR_W > DBITS) ? DR_W : DBITS;
   localparam int PW     = RB + 9;

   typedef struct packed {
      logic [C-1:0]  tx;
      logic [C-1:0]  ty;
      logic [C:0]    vx;
      logic [C:0]    vy;
      logic          none;
      logic [C-1:0]  d;
      logic [LW-1:0] num;
      logic [C-1:0]  bw;
   } item_type;

   item_type                  head, a_item_ff, b_item_ff;
   mobd_pkg::stage_state_type state_ff, state_in;

   logic              div_start, sqrt_start;
   logic              ratio_busy, lat_busy, sqrt_busy;
   logic [RB-1:0]     ratio_q, r_w, r2_ff, r3_ff;
   logic [LW-1:0]     lat_q;
   logic [2*RB-1:0]   rr, rc;
   logic [2*LW-1:0]   lat_sq, lat2_ff;
   logic [PW-1:0]     dprod;
   logic [DB-1:0]     depth_ff;
   logic [2*DB-1:0]   dep_sq, dep2_ff;
   logic [2*ROOT_W-1:0] radicand;
   logic [ROOT_W-1:0] root;
   logic [ROOT_W:0]   root_rnd;
   logic [EXT_W-1:0]  dist_ext;
   logic [DBITS-1:0]  dist_val;
   logic              b_valid_ff, b_valid_in;

   assign head = q_item;

   mobd_div #(
      .NUM_W (RB),
      .DEN_W (C)
   ) u_div_ratio (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (head.d),
      .numer    ('0),
      .denom    (head.ty),
      .busy     (ratio_busy),
      .quot     (ratio_q)
   );

   mobd_div #(
      .NUM_W (LW),
      .DEN_W (C)
   ) u_div_lat (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init ('0),
      .numer    (head.num),
      .denom    (head.bw),
      .busy     (lat_busy),
      .quot     (lat_q)
   );

   mobd_sqrt #(
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mobd_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = mobd_pkg::ST_DIV;
            end
         end
         mobd_pkg::ST_DIV: begin
            if (!ratio_busy && !lat_busy) begin
               state_in = mobd_pkg::ST_SQR;
            end
         end
         mobd_pkg::ST_SQR:      state_in = mobd_pkg::ST_CUBE;
         mobd_pkg::ST_CUBE:     state_in = mobd_pkg::ST_DEPTH;
         mobd_pkg::ST_DEPTH:    state_in = mobd_pkg::ST_DEPTH_SQ;
         mobd_pkg::ST_DEPTH_SQ: state_in = mobd_pkg::ST_HAND;
         mobd_pkg::ST_HAND: begin
            if (!b_valid_ff) begin
               state_in = mobd_pkg::ST_IDLE;
            end
         end
         default: state_in = mobd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop      = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      case (state_ff)
         mobd_pkg::ST_IDLE: begin
            q_pop     = !q_empty;
            div_start = !q_empty;
         end
         mobd_pkg::ST_HAND: begin
            sqrt_start = !b_valid_ff;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mobd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // zero frame height means a zero height fraction
   assign r_w    = (a_item_ff.ty == '0) ? '0 : ratio_q;
   assign rr     = (2 * RB)'(r_w) * (2 * RB)'(r_w);
   assign rc     = (2 * RB)'(r2_ff) * (2 * RB)'(r_w);
   assign lat_sq = (2 * LW)'(lat_q) * (2 * LW)'(lat_q);
   assign dprod  = PW'(r3_ff) * PW'(mobd_pkg::DEPTH_SCALE) + PW'(mobd_pkg::DEPTH_ROUND);
   assign dep_sq = (2 * DB)'(depth_ff) * (2 * DB)'(depth_ff);
   assign radicand = (2 * ROOT_W)'(dep2_ff) + (2 * ROOT_W)'(lat2_ff);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_item_ff <= head;
      end
      if (sqrt_start) begin
         b_item_ff <= a_item_ff;
      end
      case (state_ff)
         mobd_pkg::ST_SQR: begin
            r2_ff   <= rr[2*RB-1:RB];
            lat2_ff <= lat_sq;
         end
         mobd_pkg::ST_CUBE:     r3_ff    <= rc[2*RB-1:RB];
         mobd_pkg::ST_DEPTH:    depth_ff <= dprod[mobd_pkg::DEPTH_SHIFT +: DB];
         mobd_pkg::ST_DEPTH_SQ: dep2_ff  <= dep_sq;
         default: begin
            r3_ff <= r3_ff;
         end
      endcase
   end

   assign o_push = b_valid_ff && !sqrt_busy && !o_full;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (sqrt_start) begin
         b_valid_in = 1'b1;
      end else if (o_push) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   // round to q16.8 and saturate
   always_comb begin
      root_rnd = (ROOT_W + 1)'(root) + (ROOT_W + 1)'(mobd_pkg::DIST_ROUND);
      dist_ext = EXT_W'(root_rnd[ROOT_W:mobd_pkg::DIST_SHIFT]);
      if (b_item_ff.none) begin
         dist_val = '0;
      end else if (dist_ext > EXT_W'(mobd_pkg::DIST_MAX)) begin
         dist_val = mobd_pkg::DIST_MAX;
      end else begin
         dist_val = dist_ext[DBITS-1:0];
      end
   end

   assign o_result = {b_item_ff.tx, b_item_ff.ty, b_item_ff.vx, b_item_ff.vy, dist_val};

   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("request taken from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> ratio_busy && lat_busy)
      else $error("dividers did not start");
   assert property (@(posedge clock) disable iff (reset) sqrt_start |-> !b_valid_ff)
      else $error("square root started while occupied");
   assert property (@(posedge clock) disable iff (reset)
      o_push |-> b_valid_ff && !sqrt_busy && !o_full)
      else $error("result pushed before the root was ready");
endmodule

// ===== verif/mobd_checker.sv =====
`timescale 1ns / 1ps

module mobd_checker #(
   parameter int COORD_BITS = mobd_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic                  req_tracks_found,
   input  logic [COORD_BITS-1:0] req_left_rail_x,
   input  logic [COORD_BITS-1:0] req_right_rail_x,
   input  logic [COORD_BITS-1:0] req_box_left,
   input  logic [COORD_BITS-1:0] req_box_top,
   input  logic [COORD_BITS-1:0] req_box_width,
   input  logic [COORD_BITS-1:0] req_box_height,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [COORD_BITS-1:0] rsp_track_ref_x,
   input  logic [COORD_BITS-1:0] rsp_track_ref_y,
   input  logic [COORD_BITS:0]   rsp_vehicle_ref_x,
   input  logic [COORD_BITS:0]   rsp_vehicle_ref_y,
   input  logic [mobd_pkg::DIST_BITS-1:0] rsp_distance,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  mobd_pkg::csr_index_type csr_index,
   input  logic [COORD_BITS-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [COORD_BITS-1:0] track_x;
      logic [COORD_BITS-1:0] track_y;
      logic [COORD_BITS:0]   vehicle_x;
      logic [COORD_BITS:0]   vehicle_y;
      logic [mobd_pkg::DIST_BITS-1:0] dist_q8;
   } estimate_type;

   estimate_type          expected_estimates[$];
   logic [COORD_BITS-1:0] frame_w;
   logic [COORD_BITS-1:0] frame_h;

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic estimate_type estimate_distance(
      input logic found, input logic [63:0] lx, input logic [63:0] rx,
      input logic [63:0] bl, input logic [63:0] bt, input logic [63:0] bw,
      input logic [63:0] bh);
      logic [63:0] tx, ty, vx, vy, dist_m, gap, ratio, ratio2, ratio3, depth, adx, lat, s;
      estimate_type e;
      tx     = found ? ((lx + rx) >> 1) : (64'(frame_w) >> 1);
      ty     = 64'(frame_h);
      dist_m = 0;
      if (bw == 0) begin
         vx = tx;
         vy = ty;
      end else begin
         vx    = bl + (bw >> 1);
         vy    = bt + bh;
         gap   = (vy >= ty) ? 0 : ty - vy;
         ratio = (ty != 0) ? (gap << 30) / ty : 0;
         ratio2 = (ratio * ratio) >> 30;
         ratio3 = (ratio2 * ratio) >> 30;
         depth = (ratio3 * mobd_pkg::DEPTH_SCALE + mobd_pkg::DEPTH_ROUND)
                 >> mobd_pkg::DEPTH_SHIFT;
         adx   = (tx >= vx) ? tx - vx : vx - tx;
         lat   = (adx * mobd_pkg::LAT_SCALE + (bw >> 1)) / bw;
         s     = floor_root(depth * depth + lat * lat);
         dist_m = (s + mobd_pkg::DIST_ROUND) >> mobd_pkg::DIST_SHIFT;
         if (dist_m > 64'(mobd_pkg::DIST_MAX)) dist_m = 64'(mobd_pkg::DIST_MAX);
      end
      e.track_x   = tx[COORD_BITS-1:0];
      e.track_y   = ty[COORD_BITS-1:0];
      e.vehicle_x = vx[COORD_BITS:0];
      e.vehicle_y = vy[COORD_BITS:0];
      e.dist_q8   = dist_m[mobd_pkg::DIST_BITS-1:0];
      return e;
   endfunction

   assign pending = expected_estimates.size();

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         frame_w    <= COORD_BITS'(mobd_pkg::FRAME_WIDTH_RST);
         frame_h    <= COORD_BITS'(mobd_pkg::FRAME_HEIGHT_RST);
         fail_count <= 0;
         expected_estimates.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == mobd_pkg::CSR_FRAME_WIDTH) frame_w <= csr_data;
            else frame_h <= csr_data;
         end
         if (req_push && !req_full)
            expected_estimates.push_back(estimate_distance(req_tracks_found,
               64'(req_left_rail_x), 64'(req_right_rail_x), 64'(req_box_left),
               64'(req_box_top), 64'(req_box_width), 64'(req_box_height)));
         if (rsp_pop && !rsp_empty) begin
            if (expected_estimates.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: %0d %0d %0d %0d %0d", rsp_track_ref_x,
                     rsp_track_ref_y, rsp_vehicle_ref_x, rsp_vehicle_ref_y, rsp_distance);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_estimates.pop_front();
               if (want.track_x !== rsp_track_ref_x || want.track_y !== rsp_track_ref_y ||
                   want.vehicle_x !== rsp_vehicle_ref_x ||
                   want.vehicle_y !== rsp_vehicle_ref_y || want.dist_q8 !== rsp_distance) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                        want.track_x, want.track_y, want.vehicle_x, want.vehicle_y,
                        want.dist_q8, rsp_track_ref_x, rsp_track_ref_y, rsp_vehicle_ref_x,
                        rsp_vehicle_ref_y, rsp_distance);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CB = 12;
   localparam int STALL_LIMIT = 5000;

   logic            clock;
   logic            reset;
   logic            req_push;
   logic            req_full;
   logic            req_tracks_found;
   logic [CB-1:0]   req_left_rail_x, req_right_rail_x, req_box_left, req_box_top;
   logic [CB-1:0]   req_box_width, req_box_height;
   logic            rsp_empty;
   logic            rsp_pop;
   logic [CB-1:0]   rsp_track_ref_x, rsp_track_ref_y;
   logic [CB:0]     rsp_vehicle_ref_x, rsp_vehicle_ref_y;
   logic [mobd_pkg::DIST_BITS-1:0] rsp_distance;
   logic            csr_valid;
   logic            csr_ready;
   mobd_pkg::csr_index_type csr_index;
   logic [CB-1:0]   csr_data;
   int              fail_count;
   int              pending;

   int              send_idle_pct;
   int              recv_stall_pct;
   bit              hold_off;
   bit              hold_done;
   int              quiet_cycles;
   logic [CB-1:0]   cur_w, cur_h;

   monocular_object_distance #(.COORD_BITS(CB)) uut (.*);

   mobd_checker #(.COORD_BITS(CB)) u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side
   initial begin
      int held;
      rsp_pop = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_off && !hold_done) begin
            rsp_pop = 0;
            for (held = 0; held < 400; held++) @(negedge clock);
            hold_done = 1;
         end
         rsp_pop = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input logic found, input logic [CB-1:0] lx, rx, bl, bt, bw, bh);
      bit ok;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 0;
         @(negedge clock);
      end
      req_push = 1;
      req_tracks_found = found;
      req_left_rail_x = lx;
      req_right_rail_x = rx;
      req_box_left = bl;
      req_box_top = bt;
      req_box_width = bw;
      req_box_height = bh;
      forever begin
         ok = !req_full;
         @(posedge clock);
         if (ok) break;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_push = 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(input mobd_pkg::csr_index_type idx, input logic [CB-1:0] value);
      bit ok;
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      forever begin
         ok = csr_ready;
         @(posedge clock);
         if (ok) break;
         @(negedge clock);
      end
      @(negedge clock);
      csr_valid = 0;
      if (idx == mobd_pkg::CSR_FRAME_WIDTH) cur_w = value;
      else cur_h = value;
   endtask

   task automatic random_request();
      logic [CB-1:0] lx, rx, bl, bt, bw, bh;
      if ($urandom_range(99) < 25) begin
         send_request(1'($urandom_range(1)), CB'($urandom), CB'($urandom), CB'($urandom),
            CB'($urandom), CB'($urandom), CB'($urandom));
      end else begin
         lx = CB'($urandom_range(cur_w));
         rx = CB'($urandom_range(cur_w));
         bw = ($urandom_range(9) == 0) ? '0 : CB'($urandom_range(cur_w, 1));
         bl = CB'($urandom_range(cur_w));
         bt = CB'($urandom_range(cur_h));
         bh = CB'($urandom_range(cur_h));
         send_request(1'($urandom_range(1)), lx, rx, bl, bt, bw, bh);
      end
   endtask

   initial begin
      int phase, n;
      logic [CB-1:0] widths[4];
      logic [CB-1:0] heights[4];
      reset = 1;
      req_push = 0;
      req_tracks_found = 0;
      req_left_rail_x = 0;
      req_right_rail_x = 0;
      req_box_left = 0;
      req_box_top = 0;
      req_box_width = 0;
      req_box_height = 0;
      csr_valid = 0;
      csr_index = mobd_pkg::CSR_FRAME_WIDTH;
      csr_data = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      cur_w = CB'(mobd_pkg::FRAME_WIDTH_RST);
      cur_h = CB'(mobd_pkg::FRAME_HEIGHT_RST);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed cases, first at reset settings, then at 1x1 and 4095x4095 frames
      send_request(1, 100, 300, 150, 100, 80, 60);
      send_request(0, 100, 300, 150, 100, 80, 60);
      send_request(1, 200, 400, 10, 20, 0, 30);
      send_request(0, 0, 0, 0, 0, 0, 0);
      send_request(1, 4095, 4095, 4095, 4095, 4095, 4095);
      send_request(0, 4095, 4095, 4095, 4095, 4095, 4095);
      send_request(1, 0, 4095, 0, 0, 1, 0);
      send_request(0, 0, 0, 4095, 0, 1, 0);
      send_request(1, 320, 320, 300, 500, 40, 40);
      send_request(1, 320, 320, 300, 400, 40, 80);
      send_request(1, 320, 320, 300, 0, 40, 1);
      send_request(0, 1, 2, 0, 479, 2, 0);
      send_request(1, 2730, 1365, 1365, 2730, 2730, 1365);
      send_request(0, 0, 0, 0, 0, 4095, 4095);
      drain();
      write_csr(mobd_pkg::CSR_FRAME_WIDTH, 1);
      write_csr(mobd_pkg::CSR_FRAME_HEIGHT, 1);
      send_request(0, 5, 6, 0, 0, 1, 0);
      send_request(0, 5, 6, 0, 0, 0, 0);
      send_request(1, 4095, 0, 4095, 4095, 4095, 4095);
      drain();
      write_csr(mobd_pkg::CSR_FRAME_WIDTH, 4095);
      write_csr(mobd_pkg::CSR_FRAME_HEIGHT, 4095);
      send_request(0, 0, 0, 0, 0, 3, 0);
      send_request(1, 0, 0, 4095, 0, 1, 0);
      send_request(0, 0, 0, 2047, 4094, 2, 0);
      drain();

      widths  = '{12'd640, 12'd4095, 12'd1, 12'd1920};
      heights = '{12'd480, 12'd4095, 12'd1, 12'd1080};
      for (phase = 0; phase < 4; phase++) begin
         write_csr(mobd_pkg::CSR_FRAME_WIDTH, widths[phase]);
         write_csr(mobd_pkg::CSR_FRAME_HEIGHT, heights[phase]);
         send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 13 : 0;
         recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 13 : 0;
         for (n = 0; n < 330; n++) begin
            if (phase == 0 && n == 40) hold_off = 1;
            if (n == 200) begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            random_request();
         end
         drain();
      end

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mobd_pkg.sv
hw/rtl/mobd_fifo.sv
hw/rtl/mobd_front.sv
hw/rtl/mobd_div.sv
hw/rtl/mobd_sqrt.sv
hw/rtl/mobd_back.sv
hw/rtl/monocular_object_distance.sv
verif/mobd_checker.sv
verif/tb.sv
